### hdl/rmc_pkg.sv
// types, constants and check functions for the rmc sentence parser
package rmc_pkg;

  typedef logic [6:0] rmc_pos_t;

  localparam rmc_pos_t POS_MAX = 7'd127;
  localparam rmc_pos_t END_POS = 7'd71;

  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_STAR   = 8'h2A;
  localparam logic [7:0] CHAR_COMMA  = 8'h2C;
  localparam logic [7:0] CHAR_FIX_A  = 8'h41;

  localparam logic [4:0] ST_OK        = 5'd0;
  localparam logic [4:0] ST_NO_DOLLAR = 5'd1;
  localparam logic [4:0] ST_TYPE      = 5'd2;
  localparam logic [4:0] ST_CSUM      = 5'd3;
  localparam logic [4:0] ST_TIME      = 5'd4;
  localparam logic [4:0] ST_COMMA13   = 5'd5;
  localparam logic [4:0] ST_FIX       = 5'd6;
  localparam logic [4:0] ST_COMMA15   = 5'd7;
  localparam logic [4:0] ST_COMMA25   = 5'd8;
  localparam logic [4:0] ST_COMMA27   = 5'd9;
  localparam logic [4:0] ST_COMMA38   = 5'd10;
  localparam logic [4:0] ST_COMMA40   = 5'd11;
  localparam logic [4:0] ST_COMMA46   = 5'd12;
  localparam logic [4:0] ST_COMMA52   = 5'd13;
  localparam logic [4:0] ST_DATE      = 5'd14;
  localparam logic [4:0] ST_COMMA59   = 5'd15;
  localparam logic [4:0] ST_LENGTH    = 5'd16;

  typedef struct packed {
    logic [4:0]  status;
    logic [23:0] time_bcd;
    logic [23:0] date_bcd;
  } rmc_result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } rmc_hex_t;

  function automatic logic [7:0] type_char(rmc_pos_t p);
    logic [7:0] ch;
    case (p)
      7'd1:    ch = 8'h47;
      7'd2:    ch = 8'h50;
      7'd3:    ch = 8'h52;
      7'd4:    ch = 8'h4D;
      7'd5:    ch = 8'h43;
      7'd6:    ch = CHAR_COMMA;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic rmc_hex_t hex_decode(logic [7:0] c);
    rmc_hex_t h;
    h.ok  = 1'b1;
    h.val = c[3:0];
    if (c >= 8'h30 && c <= 8'h39) begin
      h.val = c[3:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      h.val = c[3:0] + 4'd9;
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

  // first check at or after a short line's end position
  function automatic logic [4:0] code_from(rmc_pos_t p);
    logic [4:0] code;
    if (p <= 7'd6)       code = ST_TYPE;
    else if (p <= 7'd12) code = ST_TIME;
    else if (p == 7'd13) code = ST_COMMA13;
    else if (p == 7'd14) code = ST_FIX;
    else if (p == 7'd15) code = ST_COMMA15;
    else if (p <= 7'd25) code = ST_COMMA25;
    else if (p <= 7'd27) code = ST_COMMA27;
    else if (p <= 7'd38) code = ST_COMMA38;
    else if (p <= 7'd40) code = ST_COMMA40;
    else if (p <= 7'd46) code = ST_COMMA46;
    else if (p <= 7'd52) code = ST_COMMA52;
    else if (p <= 7'd58) code = ST_DATE;
    else if (p == 7'd59) code = ST_COMMA59;
    else                 code = ST_LENGTH;
    return code;
  endfunction

  function automatic logic [4:0] layout_fail(rmc_pos_t p, logic [7:0] c);
    logic       dig;
    logic [4:0] code;
    dig  = (c >= 8'h30) && (c <= 8'h39);
    code = ST_OK;
    if (p >= 7'd1 && p <= 7'd6) begin
      if (c != type_char(p)) code = ST_TYPE;
    end else if (p >= 7'd7 && p <= 7'd12) begin
      if (!dig) code = ST_TIME;
    end else if (p >= 7'd53 && p <= 7'd58) begin
      if (!dig) code = ST_DATE;
    end else if (p == 7'd14) begin
      if (c != CHAR_FIX_A) code = ST_FIX;
    end else if (p == END_POS) begin
      code = ST_LENGTH;
    end else if (c != CHAR_COMMA) begin
      case (p)
        7'd13:   code = ST_COMMA13;
        7'd15:   code = ST_COMMA15;
        7'd25:   code = ST_COMMA25;
        7'd27:   code = ST_COMMA27;
        7'd38:   code = ST_COMMA38;
        7'd40:   code = ST_COMMA40;
        7'd46:   code = ST_COMMA46;
        7'd52:   code = ST_COMMA52;
        7'd59:   code = ST_COMMA59;
        default: code = ST_OK;
      endcase
    end
    return code;
  endfunction

endpackage

### hdl/rmc_chk.sv
// sentence state: position, checksum, layout checks and bcd capture
module rmc_chk import rmc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic [7:0]  char_in,
  input  logic        line_end,
  output rmc_result_t result,
  output rmc_pos_t    pos
);

  typedef enum logic [1:0] {CS_PENDING, CS_OK, CS_BAD} cs_t;

  logic        seen_dollar, seen_dollar_next;
  rmc_pos_t    position, position_next;
  logic [7:0]  running_xor, running_xor_next;
  rmc_pos_t    star_position, star_position_next;
  logic        star_seen, star_seen_next;
  logic [7:0]  sent_checksum, sent_checksum_next;
  cs_t         cs, cs_next;
  logic [4:0]  field_error, field_error_next;
  logic [23:0] time_digits, time_digits_next;
  logic [23:0] date_digits, date_digits_next;

  logic [4:0]  fcode;
  logic [4:0]  end_error;
  logic [4:0]  end_status;
  rmc_hex_t    hex;
  logic [2:0]  tidx;
  logic [2:0]  didx;

  assign fcode = layout_fail(position, char_in);
  assign hex   = hex_decode(char_in);
  assign tidx  = 3'(7'd12 - position);
  assign didx  = 3'(7'd58 - position);

  always_comb begin
    end_error = field_error;
    if (field_error == ST_OK && position != END_POS) end_error = code_from(position);
    if (!seen_dollar)            end_status = ST_NO_DOLLAR;
    else if (end_error == ST_TYPE) end_status = ST_TYPE;
    else if (cs != CS_OK)        end_status = ST_CSUM;
    else                         end_status = end_error;
  end

  assign result.status   = end_status;
  assign result.time_bcd = (end_status == ST_OK) ? time_digits : 24'd0;
  assign result.date_bcd = (end_status == ST_OK) ? date_digits : 24'd0;
  assign pos = position;

  always_comb begin
    seen_dollar_next   = seen_dollar;
    position_next      = position;
    running_xor_next   = running_xor;
    star_position_next = star_position;
    star_seen_next     = star_seen;
    sent_checksum_next = sent_checksum;
    cs_next            = cs;
    field_error_next   = field_error;
    time_digits_next   = time_digits;
    date_digits_next   = date_digits;
    if (step && line_end) begin
      seen_dollar_next   = 1'b0;
      position_next      = '0;
      running_xor_next   = '0;
      star_position_next = '0;
      star_seen_next     = 1'b0;
      sent_checksum_next = '0;
      cs_next            = CS_PENDING;
      field_error_next   = ST_OK;
      time_digits_next   = '0;
      date_digits_next   = '0;
    end else if (step && !seen_dollar) begin
      if (char_in == CHAR_DOLLAR) begin
        seen_dollar_next = 1'b1;
        position_next    = 7'd1;
      end
    end else if (step) begin
      if (field_error == ST_OK) field_error_next = fcode;
      if (position >= 7'd7 && position <= 7'd12) time_digits_next[tidx*4 +: 4] = char_in[3:0];
      if (position >= 7'd53 && position <= 7'd58) date_digits_next[didx*4 +: 4] = char_in[3:0];
      if (!star_seen) begin
        if (char_in == CHAR_STAR) begin
          star_seen_next     = 1'b1;
          star_position_next = position;
        end else begin
          running_xor_next = running_xor ^ char_in;
        end
      end else if (cs == CS_PENDING) begin
        if ({1'b0, position} == {1'b0, star_position} + 8'd1) begin
          if (!hex.ok) cs_next = CS_BAD;
          else         sent_checksum_next = {hex.val, 4'd0};
        end else if ({1'b0, position} == {1'b0, star_position} + 8'd2) begin
          if (!hex.ok) begin
            cs_next = CS_BAD;
          end else begin
            sent_checksum_next = sent_checksum | {4'd0, hex.val};
            cs_next = ((sent_checksum | {4'd0, hex.val}) == running_xor) ? CS_OK : CS_BAD;
          end
        end
      end
      if (position != POS_MAX) position_next = position + 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_dollar   <= 1'b0;
      position      <= '0;
      running_xor   <= '0;
      star_position <= '0;
      star_seen     <= 1'b0;
      sent_checksum <= '0;
      cs            <= CS_PENDING;
      field_error   <= ST_OK;
      time_digits   <= '0;
      date_digits   <= '0;
    end else begin
      seen_dollar   <= seen_dollar_next;
      position      <= position_next;
      running_xor   <= running_xor_next;
      star_position <= star_position_next;
      star_seen     <= star_seen_next;
      sent_checksum <= sent_checksum_next;
      cs            <= cs_next;
      field_error   <= field_error_next;
      time_digits   <= time_digits_next;
      date_digits   <= date_digits_next;
    end
  end

endmodule

### hdl/rmc_oreg.sv
// result register with valid/ready handshake
module rmc_oreg import rmc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  rmc_result_t din,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [4:0]  status,
  output logic [23:0] time_bcd,
  output logic [23:0] date_bcd
);

  rmc_result_t held;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (load) begin
      held <= din;
    end
  end

  assign status   = held.status;
  assign time_bcd = held.time_bcd;
  assign date_bcd = held.date_bcd;

endmodule

### hdl/nmea_rmc_time_date_parser_unit.sv
// top level of the rmc time/date sentence parser
// a line-end word passes through the input register, then its result is loaded into the result register
// throughput: one word per cycle; a line-end word waits in the input register
//   only while the result register holds a result that has not been taken
// reset (rst, synchronous): clears the input register, the parser state and out_valid
module nmea_rmc_time_date_parser_unit import rmc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  char_in,
  input  logic        line_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  status,
  output logic [23:0] time_bcd,
  output logic [23:0] date_bcd
);

  logic        s1_valid;
  logic [7:0]  s1_char;
  logic        s1_end;
  logic        s1_go;
  rmc_result_t result;
  rmc_pos_t    pos;

  assign s1_go    = s1_valid && (!s1_end || !out_valid || out_ready);
  assign in_ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_char <= char_in;
      s1_end  <= line_end;
    end
  end

  rmc_chk u_chk (
    .clk      (clk),
    .rst      (rst),
    .step     (s1_go),
    .char_in  (s1_char),
    .line_end (s1_end),
    .result   (result),
    .pos      (pos)
  );

  rmc_oreg u_oreg (
    .clk       (clk),
    .rst       (rst),
    .load      (s1_go && s1_end),
    .din       (result),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .status    (status),
    .time_bcd  (time_bcd),
    .date_bcd  (date_bcd)
  );

  a_zero_on_fail: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> time_bcd == 24'd0 && date_bcd == 24'd0)
    else $error("bcd fields not cleared on failed sentence");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= ST_LENGTH)
    else $error("status code out of range");

  a_line_restart: assert property (@(posedge clk) disable iff (rst)
    s1_go && s1_end |=> pos == '0)
    else $error("parser state not cleared after line end");

  a_stall_held: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> s1_valid && s1_end && out_valid && !out_ready)
    else $error("input stalled without a blocked result");

endmodule

### sim/rmc_line_checker.sv
// checker for the rmc parser: predicts each line's result from accepted words and compares
`timescale 1ns / 1ps
module rmc_line_checker import rmc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  char_in,
  input  logic        line_end,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [4:0]  status,
  input  logic [23:0] time_bcd,
  input  logic [23:0] date_bcd,
  output int          errors,
  output int          waiting
);

  typedef enum logic [1:0] {SUM_PENDING, SUM_GOOD, SUM_BAD} sum_state_t;

  localparam logic [47:0] TYPE_TEXT = "GPRMC,";

  logic        got_dollar;
  rmc_pos_t    pos;
  logic [7:0]  xor_acc;
  rmc_pos_t    star_pos;
  logic        star_seen;
  logic [7:0]  sent_sum;
  sum_state_t  sum_state;
  logic [4:0]  field_err;
  logic [23:0] time_dig;
  logic [23:0] date_dig;

  rmc_result_t pending_results[$];
  int          mismatches = 0;

  // code of the layout check made at position q, ST_OK where nothing is checked
  function automatic logic [4:0] check_at(int q);
    logic [4:0] code;
    code = ST_OK;
    if (q >= 1 && q <= 6) begin
      code = ST_TYPE;
    end else if (q >= 7 && q <= 12) begin
      code = ST_TIME;
    end else if (q >= 53 && q <= 58) begin
      code = ST_DATE;
    end else begin
      case (q)
        13:      code = ST_COMMA13;
        14:      code = ST_FIX;
        15:      code = ST_COMMA15;
        25:      code = ST_COMMA25;
        27:      code = ST_COMMA27;
        38:      code = ST_COMMA38;
        40:      code = ST_COMMA40;
        46:      code = ST_COMMA46;
        52:      code = ST_COMMA52;
        59:      code = ST_COMMA59;
        END_POS: code = ST_LENGTH;
        default: code = ST_OK;
      endcase
    end
    return code;
  endfunction

  function automatic int hex_nibble(logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
    if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h37);
    if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h57);
    return -1;
  endfunction

  task automatic clear_line();
    got_dollar = 1'b0;
    pos        = '0;
    xor_acc    = '0;
    star_pos   = '0;
    star_seen  = 1'b0;
    sent_sum   = '0;
    sum_state  = SUM_PENDING;
    field_err  = ST_OK;
    time_dig   = '0;
    date_dig   = '0;
  endtask

  task automatic note_field(int p, logic [7:0] c);
    logic [4:0] code;
    logic       bad;
    logic       is_digit;
    code     = check_at(p);
    is_digit = (c >= 8'h30) && (c <= 8'h39);
    bad      = 1'b0;
    case (code)
      ST_OK:     bad = 1'b0;
      ST_TYPE:   bad = (c != TYPE_TEXT[(6 - p) * 8 +: 8]);
      ST_TIME: begin
        bad = !is_digit;
        time_dig = time_dig | ({20'h0, c[3:0]} << ((12 - p) * 4));
      end
      ST_DATE: begin
        bad = !is_digit;
        date_dig = date_dig | ({20'h0, c[3:0]} << ((58 - p) * 4));
      end
      ST_FIX:    bad = (c != CHAR_FIX_A);
      ST_LENGTH: bad = 1'b1;
      default:   bad = (c != CHAR_COMMA);
    endcase
    if (bad && field_err == ST_OK) field_err = code;
  endtask

  task automatic note_checksum(int p, logic [7:0] c);
    int v;
    v = hex_nibble(c);
    if (!star_seen) begin
      if (c == CHAR_STAR) begin
        star_seen = 1'b1;
        star_pos  = rmc_pos_t'(p);
      end else begin
        xor_acc = xor_acc ^ c;
      end
    end else if (sum_state == SUM_PENDING) begin
      if (p == int'(star_pos) + 1) begin
        if (v < 0) sum_state = SUM_BAD;
        else sent_sum = {v[3:0], 4'h0};
      end else if (p == int'(star_pos) + 2) begin
        if (v < 0) begin
          sum_state = SUM_BAD;
        end else begin
          sent_sum[3:0] = v[3:0];
          sum_state = (sent_sum == xor_acc) ? SUM_GOOD : SUM_BAD;
        end
      end
    end
  endtask

  task automatic parse_word(logic [7:0] c, logic e);
    int          p;
    int          q;
    logic [4:0]  st;
    rmc_result_t r;
    p = int'(pos);
    if (!e) begin
      if (!got_dollar) begin
        if (c == CHAR_DOLLAR) begin
          got_dollar = 1'b1;
          pos = 7'd1;
        end
      end else begin
        note_field(p, c);
        note_checksum(p, c);
        if (pos < POS_MAX) pos = pos + 7'd1;
      end
    end else begin
      if (!got_dollar) begin
        st = ST_NO_DOLLAR;
      end else begin
        // short line: first check at or after the line's end position fails
        if (field_err == ST_OK && p != int'(END_POS)) begin
          field_err = ST_LENGTH;
          for (q = int'(END_POS); q >= p; q--) begin
            if (check_at(q) != ST_OK) field_err = check_at(q);
          end
        end
        if (field_err == ST_TYPE) st = ST_TYPE;
        else if (sum_state != SUM_GOOD) st = ST_CSUM;
        else st = field_err;
      end
      r.status   = st;
      r.time_bcd = (st == ST_OK) ? time_dig : '0;
      r.date_bcd = (st == ST_OK) ? date_dig : '0;
      pending_results.push_back(r);
      clear_line();
    end
  endtask

  always @(posedge clk) begin
    rmc_result_t want;
    if (rst) begin
      clear_line();
      pending_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result: status %0d time %06h date %06h",
                     status, time_bcd, date_bcd);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (status !== want.status || time_bcd !== want.time_bcd ||
              date_bcd !== want.date_bcd) begin
            if (mismatches < 10)
              $display("mismatch: expected status %0d time %06h date %06h, got %0d %06h %06h",
                       want.status, want.time_bcd, want.date_bcd,
                       status, time_bcd, date_bcd);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) parse_word(char_in, line_end);
    end
    errors  <= mismatches;
    waiting <= pending_results.size();
  end

endmodule

### sim/tb_nmea_rmc_time_date_parser_unit.sv
// testbench top for the rmc parser: sentence stimulus, output stalls and the verdict
`timescale 1ns / 1ps
module tb_nmea_rmc_time_date_parser_unit;
  import rmc_pkg::*;

  localparam int CYCLE_LIMIT = 800000;
  localparam int HOLD_CYCLES = 300;
  localparam logic [47:0] TYPE_TEXT = "GPRMC,";

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  char_in;
  logic        line_end;
  logic        out_valid;
  logic        out_ready;
  logic [4:0]  status;
  logic [23:0] time_bcd;
  logic [23:0] date_bcd;

  int errors;
  int waiting;
  int cycles = 0;
  bit calm = 1'b0;
  bit hold_off = 1'b0;
  bit hold_done = 1'b0;

  logic [7:0] line_q[$];
  int comma_pos[9] = '{13, 15, 25, 27, 38, 40, 46, 52, 59};

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  nmea_rmc_time_date_parser_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .char_in   (char_in),
    .line_end  (line_end),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .time_bcd  (time_bcd),
    .date_bcd  (date_bcd)
  );

  rmc_line_checker line_checker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .char_in   (char_in),
    .line_end  (line_end),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .time_bcd  (time_bcd),
    .date_bcd  (date_bcd),
    .errors    (errors),
    .waiting   (waiting)
  );

  function automatic logic [7:0] noise_byte();
    logic [7:0] v;
    v = 8'($urandom_range(0, 255));
    if (v == CHAR_DOLLAR) v = 8'h00;
    return v;
  endfunction

  // any byte but the star, so the checksum ends where it is placed
  function automatic logic [7:0] free_byte();
    logic [7:0] v;
    if ($urandom_range(0, 1) == 0) v = 8'($urandom_range(8'h20, 8'h7e));
    else v = 8'($urandom_range(0, 255));
    if (v == CHAR_STAR) v = 8'h2e;
    return v;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n, bit lower);
    if (n < 4'd10) return 8'h30 + {4'h0, n};
    return (lower ? 8'h57 : 8'h37) + {4'h0, n};
  endfunction

  // digits: 0 random, 1 all zero, 2 all nine
  task automatic fill_line(int len, int digits);
    int         q;
    logic       is_comma;
    logic [7:0] b;
    line_q.delete();
    line_q.push_back(CHAR_DOLLAR);
    for (q = 1; q < len; q++) begin
      is_comma = 1'b0;
      foreach (comma_pos[i]) if (comma_pos[i] == q) is_comma = 1'b1;
      if (q <= 6) begin
        b = TYPE_TEXT[(6 - q) * 8 +: 8];
      end else if ((q >= 7 && q <= 12) || (q >= 53 && q <= 58)) begin
        case (digits)
          1:       b = 8'h30;
          2:       b = 8'h39;
          default: b = 8'h30 + 8'($urandom_range(0, 9));
        endcase
      end else if (q == 14) begin
        b = CHAR_FIX_A;
      end else if (is_comma) begin
        b = CHAR_COMMA;
      end else begin
        b = free_byte();
      end
      line_q.push_back(b);
    end
  endtask

  // star_at 0 leaves the line without a checksum
  task automatic seal_line(int star_at, bit flip, bit bad_hex, bit lower);
    logic [7:0] sum;
    int         q;
    if (star_at > 0 && star_at < line_q.size()) begin
      line_q[star_at] = CHAR_STAR;
      sum = 8'h00;
      for (q = 1; q < star_at; q++) sum = sum ^ line_q[q];
      if (flip) sum = sum ^ 8'($urandom_range(1, 255));
      if (star_at + 1 < line_q.size())
        line_q[star_at + 1] = bad_hex ? 8'h47 : hex_char(sum[7:4], lower);
      if (star_at + 2 < line_q.size())
        line_q[star_at + 2] = hex_char(sum[3:0], lower);
    end
  endtask

  task automatic send_word(logic [7:0] c, logic e);
    if (!calm && $urandom_range(0, 15) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    char_in  <= c;
    line_end <= e;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_line(int preamble);
    repeat (preamble) send_word(noise_byte(), 1'b0);
    foreach (line_q[i]) send_word(line_q[i], 1'b0);
    send_word(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // line with no dollar at all
  task automatic send_bare(int n);
    repeat (n) send_word(noise_byte(), 1'b0);
    send_word(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic random_line();
    int kind;
    int len;
    int star;
    kind = $urandom_range(0, 99);
    if (kind < 6) begin
      send_bare($urandom_range(0, 8));
      return;
    end
    if (kind < 50) begin
      len  = 71;
      star = $urandom_range(60, 68);
    end else if (kind < 64) begin
      len  = 71;
      star = $urandom_range(55, 70);
    end else if (kind < 82) begin
      len  = $urandom_range(1, 70);
      star = $urandom_range(1, len);
    end else if (kind < 90) begin
      len  = $urandom_range(72, 140);
      star = $urandom_range(60, 130);
    end else begin
      len  = 71;
      star = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(60, 68);
    end
    fill_line(len, ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0);
    if (len > 1 && ((kind >= 50 && kind < 64) ||
                    (kind >= 64 && kind < 82 && $urandom_range(0, 2) == 0)))
      repeat ($urandom_range(1, 3)) line_q[$urandom_range(1, len - 1)] = 8'($urandom_range(0, 255));
    seal_line(star, kind >= 90 && $urandom_range(0, 1) == 1,
              kind >= 90 && $urandom_range(0, 1) == 1, $urandom_range(0, 1) == 1);
    send_line(($urandom_range(0, 4) == 0) ? $urandom_range(1, 5) : 0);
  endtask

  // output side: random stalls, one long hold-off
  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (hold_off && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int n;
    rst      <= 1'b1;
    in_valid <= 1'b0;
    char_in  <= 8'h00;
    line_end <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // well-formed lines, digit extremes, both hex cases
    fill_line(71, 1); seal_line(68, 1'b0, 1'b0, 1'b0); send_line(0);
    fill_line(71, 2); seal_line(60, 1'b0, 1'b0, 1'b1); send_line(0);
    // no dollar
    send_bare(0);
    send_bare(5);
    // short in the type field
    fill_line(1, 0); send_line(0);
    fill_line(4, 0); send_line(0);
    // wrong type
    fill_line(12, 0); line_q[3] = 8'h58; send_line(0);
    // checksum wrong, missing, bad hex, second digit missing
    fill_line(20, 0); seal_line(16, 1'b1, 1'b0, 1'b0); send_line(0);
    fill_line(20, 0); send_line(0);
    fill_line(20, 0); seal_line(16, 1'b0, 1'b1, 1'b1); send_line(0);
    fill_line(20, 0); seal_line(18, 1'b0, 1'b0, 1'b0); send_line(0);
    // time digit, fix flag
    fill_line(20, 0); line_q[9] = 8'h61; seal_line(16, 1'b0, 1'b0, 1'b0); send_line(0);
    fill_line(20, 0); line_q[14] = 8'h56; seal_line(16, 1'b0, 1'b0, 1'b1); send_line(0);
    // every comma; from comma 25 on, the line ends just after it
    foreach (comma_pos[i]) begin
      fill_line((comma_pos[i] < 19) ? 20 : comma_pos[i] + 1, 0);
      line_q[comma_pos[i]] = 8'h3b;
      seal_line(16, 1'b0, 1'b0, (i % 2) == 1);
      send_line(0);
    end
    // date digit
    fill_line(57, 0); line_q[55] = 8'h3a; seal_line(16, 1'b0, 1'b0, 1'b0); send_line(0);
    // one byte too long
    fill_line(72, 0); seal_line(68, 1'b0, 1'b0, 1'b0); send_line(0);
    // position saturation with the star near the top
    fill_line(140, 0); seal_line(126, 1'b0, 1'b0, 1'b0); send_line(0);
    // short line, good early checksum, second dollar inside, after some noise
    fill_line(30, 0); line_q[20] = CHAR_DOLLAR; seal_line(22, 1'b0, 1'b0, 1'b1); send_line(3);

    hold_off <= 1'b1;
    repeat (12) send_bare($urandom_range(0, 1));

    for (n = 0; n < 2; n++) begin
      if (n == 1) calm = 1'b1;
      random_line();
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

### sim.f
hdl/rmc_pkg.sv
hdl/rmc_chk.sv
hdl/rmc_oreg.sv
hdl/nmea_rmc_time_date_parser_unit.sv
sim/rmc_line_checker.sv
sim/tb_nmea_rmc_time_date_parser_unit.sv
